[sv/grid_min_path_sum_unit_macros.svh]
// assertion macros shared by the grid path sum unit
`ifndef GRID_MIN_PATH_SUM_UNIT_MACROS_SVH
`define GRID_MIN_PATH_SUM_UNIT_MACROS_SVH

// condition must never hold while out of reset
`define GMPS_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// when pre holds, post must hold in the next cycle
`define GMPS_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

[sv/gmps_pkg.sv]
// shared types, constants and helpers of the grid path sum unit
package gmps_pkg;

    localparam int DEF_MAX_COLS  = 256;
    localparam int DEF_MAX_ROWS  = 256;
    localparam int DEF_COST_BITS = 16;

    localparam int SUM_BITS    = 25;
    localparam int CFG_BITS    = 9;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [0:0] {
        REG_ROW_COUNT = 1'b0,
        REG_COL_COUNT = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic first_row;
        logic first_col;
        logic is_final;
    } gmps_flags_t;

    localparam int FLAGS_BITS = $bits(gmps_flags_t);

    // zero acts as one, anything above the limit acts as the limit
    function automatic logic [CFG_BITS-1:0] clamp_count(input logic [CFG_BITS-1:0] value,
                                                       input int limit);
        logic [CFG_BITS-1:0] res;
        if (value == '0)
        begin
            res = CFG_BITS'(1);
        end
        else if (32'(value) > limit)
        begin
            res = CFG_BITS'(limit);
        end
        else
        begin
            res = value;
        end
        return res;
    endfunction

endpackage

[sv/grid_min_path_sum_unit.sv]
// top level of the grid minimum path sum unit
// an accepted cell passes through the queue, the back stage registers and the output register to the output
// throughput: one cell per cycle while out_ready is not held low, served by the row store's read port and write port
// the front takes a new cell whenever the two-entry queue has room
// reset clears position, counts (to one) and all valid flags at once
// the row store is not cleared; no clearing pass, the block is ready right after reset
`include "grid_min_path_sum_unit_macros.svh"

module grid_min_path_sum_unit
    import gmps_pkg::*;
#(
    parameter int MAX_COLS  = DEF_MAX_COLS,
    parameter int MAX_ROWS  = DEF_MAX_ROWS,
    parameter int COST_BITS = DEF_COST_BITS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // configuration write port, index 0 row count, index 1 column count
    input  logic                        cfg_write,
    input  cfg_reg_t                    cfg_index,
    input  logic [CFG_BITS-1:0]         cfg_data,
    // input beats: one cell cost each, row-major order
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic signed [COST_BITS-1:0] cell_cost,
    // output beats: path sum for each cell, flag on the bottom-right cell
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [SUM_BITS-1:0]  path_cost,
    output logic                        is_final
);

    localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int QW = COST_BITS + CW + FLAGS_BITS;

    // front to queue
    logic                 q_push;
    logic [COST_BITS-1:0] f_cost;
    logic [CW-1:0]        f_col;
    gmps_flags_t          f_flags;

    // queue to back
    logic                 q_pop;
    logic                 q_full;
    logic                 q_empty;
    logic [QW-1:0]        q_data;

    // front: tracks grid position and tags each cell with its edge flags
    gmps_front #(
        .MAX_COLS  (MAX_COLS),
        .MAX_ROWS  (MAX_ROWS),
        .COST_BITS (COST_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cell_cost  (cell_cost),
        .q_full     (q_full),
        .push       (q_push),
        .push_cost  (f_cost),
        .push_col   (f_col),
        .push_flags (f_flags)
    );

    // decoupling queue so the input side keeps going while the back stalls
    gmps_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data ({f_cost, f_col, f_flags}),
        .pop       (q_pop),
        .pop_data  (q_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    // back: row store read, min of above and left, add, saturate, output register
    gmps_back #(
        .MAX_COLS  (MAX_COLS),
        .COST_BITS (COST_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_cost    (q_data[QW-1 -: COST_BITS]),
        .q_col     (q_data[FLAGS_BITS +: CW]),
        .q_flags   (gmps_flags_t'(q_data[FLAGS_BITS-1:0])),
        .pop       (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .path_cost (path_cost),
        .is_final  (is_final)
    );

    // queue must never be overrun or read while empty
    `GMPS_NEVER(a_no_push_when_full, q_push && q_full, "queue pushed while full")
    `GMPS_NEVER(a_no_pop_when_empty, q_pop && q_empty, "queue popped while empty")
    // an accepted beat is held in the queue on the next cycle
    `GMPS_NEXT(a_accept_fills_queue, in_valid && in_ready, !q_empty,
               "accepted beat missing from queue")

endmodule

[sv/gmps_ram.sv]
// generic single write port ram with registered read
module gmps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic                                 re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[sv/gmps_queue.sv]
// small register queue between the front and the back
module gmps_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             full,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[sv/gmps_front.sv]
// front end: config registers, grid position tracking, cell classification
module gmps_front
    import gmps_pkg::*;
#(
    parameter int MAX_COLS  = DEF_MAX_COLS,
    parameter int MAX_ROWS  = DEF_MAX_ROWS,
    parameter int COST_BITS = DEF_COST_BITS
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         cfg_write,
    input  cfg_reg_t                                     cfg_index,
    input  logic [CFG_BITS-1:0]                          cfg_data,
    input  logic                                         in_valid,
    output logic                                         in_ready,
    input  logic signed [COST_BITS-1:0]                  cell_cost,
    input  logic                                         q_full,
    output logic                                         push,
    output logic [COST_BITS-1:0]                         push_cost,
    output logic [(MAX_COLS > 1 ? $clog2(MAX_COLS) : 1)-1:0] push_col,
    output gmps_flags_t                                  push_flags
);

    localparam int CW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int IW   = (CW > RW) ? CW : RW;
    localparam int CMPW = ((IW + 1) > (CFG_BITS + 1)) ? (IW + 1) : (CFG_BITS + 1);

    logic [CFG_BITS-1:0] row_count_reg, row_count_next;
    logic [CFG_BITS-1:0] col_count_reg, col_count_next;
    logic [CW-1:0]       col_reg, col_next;
    logic [RW-1:0]       row_reg, row_next;
    logic                last_col;
    logic                last_row;

    assign in_ready = !q_full;
    assign push     = in_valid && in_ready;

    assign last_col = (CMPW'(col_reg) + CMPW'(1)) >= CMPW'(col_count_reg);
    assign last_row = (CMPW'(row_reg) + CMPW'(1)) >= CMPW'(row_count_reg);

    assign push_cost            = cell_cost;
    assign push_col             = col_reg;
    assign push_flags.first_row = (row_reg == '0);
    assign push_flags.first_col = (col_reg == '0);
    assign push_flags.is_final  = last_col && last_row;

    always_comb
    begin
        row_count_next = row_count_reg;
        col_count_next = col_count_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        if (cfg_write)
        begin
            // any register write restarts the grid at the top-left cell
            case (cfg_index)
                REG_ROW_COUNT: row_count_next = clamp_count(cfg_data, MAX_ROWS);
                REG_COL_COUNT: col_count_next = clamp_count(cfg_data, MAX_COLS);
                default: ;
            endcase
            col_next = '0;
            row_next = '0;
        end
        else if (push)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + RW'(1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= CFG_BITS'(1);
            col_count_reg <= CFG_BITS'(1);
            col_reg       <= '0;
            row_reg       <= '0;
        end
        else
        begin
            row_count_reg <= row_count_next;
            col_count_reg <= col_count_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
        end
    end

endmodule

[sv/gmps_back.sv]
// back end: row store lookup, min and add, saturation, output register
module gmps_back
    import gmps_pkg::*;
#(
    parameter int MAX_COLS  = DEF_MAX_COLS,
    parameter int COST_BITS = DEF_COST_BITS
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         q_empty,
    input  logic [COST_BITS-1:0]                         q_cost,
    input  logic [(MAX_COLS > 1 ? $clog2(MAX_COLS) : 1)-1:0] q_col,
    input  gmps_flags_t                                  q_flags,
    output logic                                         pop,
    output logic                                         out_valid,
    input  logic                                         out_ready,
    output logic signed [SUM_BITS-1:0]                   path_cost,
    output logic                                         is_final
);

    localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ADD_W = ((COST_BITS > SUM_BITS) ? COST_BITS : SUM_BITS) + 1;

    logic                        b_valid_reg, b_valid_next;
    logic signed [COST_BITS-1:0] b_cost_reg;
    logic [CW-1:0]               b_col_reg;
    gmps_flags_t                 b_flags_reg;
    logic                        fwd_reg;
    logic [SUM_BITS-1:0]         fwd_data_reg;
    logic signed [SUM_BITS-1:0]  left_reg;
    logic                        out_valid_reg, out_valid_next;
    logic signed [SUM_BITS-1:0]  out_cost_reg;
    logic                        out_final_reg;

    logic                        fire;
    logic [SUM_BITS-1:0]         ram_rdata;
    logic signed [SUM_BITS-1:0]  above;
    logic signed [SUM_BITS-1:0]  prior;
    logic signed [ADD_W-1:0]     sum_wide;
    logic signed [SUM_BITS-1:0]  sum;
    logic [ADD_W-SUM_BITS:0]     top_bits;

    assign fire = b_valid_reg && (!out_valid_reg || out_ready);
    assign pop  = !q_empty && (!b_valid_reg || fire);

    gmps_ram #(
        .WIDTH (SUM_BITS),
        .DEPTH (MAX_COLS)
    ) u_row_store (
        .clk   (clk),
        .we    (fire),
        .waddr (b_col_reg),
        .wdata (sum),
        .re    (pop),
        .raddr (q_col),
        .rdata (ram_rdata)
    );

    // a write to the address read in the same cycle is forwarded
    assign above = fwd_reg ? $signed(fwd_data_reg) : $signed(ram_rdata);

    always_comb
    begin
        if (b_flags_reg.first_row && b_flags_reg.first_col)
        begin
            prior = '0;
        end
        else if (b_flags_reg.first_row)
        begin
            prior = left_reg;
        end
        else if (b_flags_reg.first_col)
        begin
            prior = above;
        end
        else
        begin
            prior = (above < left_reg) ? above : left_reg;
        end
    end

    assign sum_wide = ADD_W'(prior) + ADD_W'(b_cost_reg);
    assign top_bits = sum_wide[ADD_W-1:SUM_BITS-1];

    always_comb
    begin
        if ((&top_bits) || !(|top_bits))
        begin
            sum = sum_wide[SUM_BITS-1:0];
        end
        else if (sum_wide[ADD_W-1])
        begin
            sum = {1'b1, {(SUM_BITS-1){1'b0}}};
        end
        else
        begin
            sum = {1'b0, {(SUM_BITS-1){1'b1}}};
        end
    end

    always_comb
    begin
        b_valid_next = b_valid_reg;
        if (pop)
        begin
            b_valid_next = 1'b1;
        end
        else if (fire)
        begin
            b_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            fwd_reg       <= 1'b0;
            left_reg      <= '0;
        end
        else
        begin
            b_valid_reg   <= b_valid_next;
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                fwd_reg <= fire && (b_col_reg == q_col);
            end
            if (fire)
            begin
                left_reg <= sum;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            b_cost_reg   <= $signed(q_cost);
            b_col_reg    <= q_col;
            b_flags_reg  <= q_flags;
            fwd_data_reg <= sum;
        end
        if (fire)
        begin
            out_cost_reg  <= sum;
            out_final_reg <= b_flags_reg.is_final;
        end
    end

    assign out_valid = out_valid_reg;
    assign path_cost = out_cost_reg;
    assign is_final  = out_final_reg;

endmodule

[sim/gmps_checker.sv]
// checker for the grid path sum unit: tracks the grid, predicts each path sum and compares beats
`timescale 1ns / 1ps

module gmps_checker
    import gmps_pkg::*;
#(
    parameter int MAX_COLS  = DEF_MAX_COLS,
    parameter int MAX_ROWS  = DEF_MAX_ROWS,
    parameter int COST_BITS = DEF_COST_BITS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write,
    input  cfg_reg_t                    cfg_index,
    input  logic [CFG_BITS-1:0]         cfg_data,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic signed [COST_BITS-1:0] cell_cost,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic signed [SUM_BITS-1:0]  path_cost,
    input  logic                        is_final,
    output int                          fail_count,
    output int                          cells_pending
);

    localparam longint SUM_HI = (longint'(1) <<< (SUM_BITS - 1)) - 1;
    localparam longint SUM_LO = -(longint'(1) <<< (SUM_BITS - 1));

    typedef struct {
        logic signed [SUM_BITS-1:0] cost_sum;
        logic                       final_cell;
    } path_sum_t;

    path_sum_t                  sums_due[$];
    logic signed [SUM_BITS-1:0] prev_row_sums [MAX_COLS];
    logic signed [SUM_BITS-1:0] left_sum = '0;
    int                         row_pos = 0;
    int                         col_pos = 0;
    int                         rows_used = 1;
    int                         cols_used = 1;
    int                         mismatches = 0;

    assign fail_count = mismatches;

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("mismatch at %0t: %s", $realtime, what);
    endtask

    // zero acts as one, anything past the store size acts as the full size
    function automatic int size_limit(input logic [CFG_BITS-1:0] value, input int most);
        int n;
        n = int'(value);
        if (n == 0)
        begin
            n = 1;
        end
        else if (n > most)
        begin
            n = most;
        end
        return n;
    endfunction

    // one dp step over the single row of sums
    task automatic accumulate_cell(input logic signed [COST_BITS-1:0] cost);
        longint    prior;
        longint    total;
        int        c;
        logic      last_col;
        logic      last_row;
        path_sum_t r;
        c = (col_pos >= MAX_COLS) ? MAX_COLS - 1 : col_pos;
        if (row_pos == 0 && c == 0)
        begin
            prior = 0;
        end
        else if (row_pos == 0)
        begin
            prior = left_sum;
        end
        else if (c == 0)
        begin
            prior = prev_row_sums[c];
        end
        else
        begin
            prior = (prev_row_sums[c] < left_sum) ? prev_row_sums[c] : left_sum;
        end
        total = prior + longint'(cost);
        if (total > SUM_HI)
        begin
            total = SUM_HI;
        end
        else if (total < SUM_LO)
        begin
            total = SUM_LO;
        end
        prev_row_sums[c] = SUM_BITS'(total);
        left_sum         = SUM_BITS'(total);
        last_col         = (c + 1 >= cols_used);
        last_row         = (row_pos + 1 >= rows_used);
        r.cost_sum       = SUM_BITS'(total);
        r.final_cell     = last_col && last_row;
        sums_due.push_back(r);
        if (last_col)
        begin
            col_pos  = 0;
            left_sum = '0;
            row_pos  = last_row ? 0 : row_pos + 1;
        end
        else
        begin
            col_pos = c + 1;
        end
    endtask

    task automatic check_beat();
        path_sum_t want;
        if (sums_due.size() == 0)
        begin
            report_mismatch($sformatf("path sum beat %0d with no cell waiting", path_cost));
        end
        else
        begin
            want = sums_due.pop_front();
            if (path_cost !== want.cost_sum)
            begin
                report_mismatch($sformatf("path_cost got %0d want %0d",
                                          path_cost, want.cost_sum));
            end
            if (is_final !== want.final_cell)
            begin
                report_mismatch($sformatf("is_final got %b want %b (path_cost %0d)",
                                          is_final, want.final_cell, want.cost_sum));
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sums_due.delete();
            row_pos       = 0;
            col_pos       = 0;
            left_sum      = '0;
            rows_used     = 1;
            cols_used     = 1;
            cells_pending <= 0;
        end
        else
        begin
            // any register write restarts the grid
            if (cfg_write)
            begin
                if (cfg_index == REG_ROW_COUNT)
                begin
                    rows_used = size_limit(cfg_data, MAX_ROWS);
                end
                else
                begin
                    cols_used = size_limit(cfg_data, MAX_COLS);
                end
                row_pos  = 0;
                col_pos  = 0;
                left_sum = '0;
            end
            // outgoing beat first, so it never meets a cell taken at the same edge
            if (out_valid && out_ready)
            begin
                check_beat();
            end
            if (in_valid && in_ready)
            begin
                accumulate_cell(cell_cost);
            end
            cells_pending <= sums_due.size();
        end
    end

endmodule

[sim/tb_top.sv]
// testbench top for the grid path sum unit: stimulus, flow control and verdict
`timescale 1ns / 1ps

module tb_top
    import gmps_pkg::*;
();

    // run shape
    localparam int RANDOM_CELLS = 230;
    localparam int HOLD_CYCLES  = 80;
    localparam int HOLD_CELLS   = 40;
    localparam int DRAIN_CYCLES = 12;   // slack after the last path sum is back
    localparam int CYCLE_LIMIT  = 300000;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            cfg_write = 1'b0;
    cfg_reg_t                        cfg_index = REG_ROW_COUNT;
    logic [CFG_BITS-1:0]             cfg_data = '0;
    logic                            in_valid = 1'b0;
    logic                            in_ready;
    logic signed [DEF_COST_BITS-1:0] cell_cost = '0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    logic signed [SUM_BITS-1:0]      path_cost;
    logic                            is_final;

    int fail_count;
    int cells_pending;

    // flow control knobs, in percent per cycle
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    // a flip of hold_toggle asks the receiver for one long hold-off
    logic hold_toggle = 1'b0;
    logic hold_seen;
    int   hold_left;

    int   cycle_count = 0;
    int   random_sent;
    int   phase;
    int   rows_eff;
    int   cols_eff;
    int   grid_cells;
    int   burst;
    int   pick;
    logic [CFG_BITS-1:0] size_val;

    grid_min_path_sum_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cell_cost (cell_cost),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .path_cost (path_cost),
        .is_final  (is_final)
    );

    gmps_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .cell_cost     (cell_cost),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .path_cost     (path_cost),
        .is_final      (is_final),
        .fail_count    (fail_count),
        .cells_pending (cells_pending)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // watchdog: a hung handshake ends the run as a failure
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiver: random stalls, or a long hold-off counted here when asked for
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_seen <= 1'b0;
            hold_left <= 0;
        end
        else if (hold_toggle != hold_seen)
        begin
            hold_seen <= hold_toggle;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // full-range costs half the time, with extremes and small values mixed in
    function automatic logic signed [DEF_COST_BITS-1:0] pick_cost();
        logic signed [DEF_COST_BITS-1:0] v;
        case ($urandom_range(9))
            0:       v = 16'sh7fff;
            1:       v = 16'sh8000;
            2, 3, 4: v = DEF_COST_BITS'(int'($urandom_range(200)) - 100);
            default: v = DEF_COST_BITS'($urandom);
        endcase
        return v;
    endfunction

    // register value: mostly small grids, now and then zero, the maximum or beyond
    function automatic logic [CFG_BITS-1:0] pick_size(input int usual_max);
        logic [CFG_BITS-1:0] v;
        case ($urandom_range(11))
            0:       v = '0;
            1:       v = CFG_BITS'($urandom_range(511, 257));
            2:       v = CFG_BITS'(256);
            default: v = CFG_BITS'($urandom_range(usual_max, 1));
        endcase
        return v;
    endfunction

    // size the block will actually use for a register value
    function automatic int size_in_use(input logic [CFG_BITS-1:0] value, input int most);
        int n;
        n = int'(value);
        if (n == 0)
        begin
            n = 1;
        end
        else if (n > most)
        begin
            n = most;
        end
        return n;
    endfunction

    // offer one cell and wait for its beat to be taken, then maybe idle
    task automatic send_cell(input logic signed [DEF_COST_BITS-1:0] cost);
        in_valid  <= 1'b1;
        cell_cost <= cost;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
            begin
                @(posedge clk);
            end
            while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    // stop offering and wait until every path sum has come back
    task automatic settle();
        in_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (cells_pending != 0);
    endtask

    // registers only change while the block is empty
    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_BITS-1:0] value);
        settle();
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic set_grid(input logic [CFG_BITS-1:0] rows, input logic [CFG_BITS-1:0] cols);
        write_reg(REG_ROW_COUNT, rows);
        write_reg(REG_COL_COUNT, cols);
    endtask

    task automatic set_flow(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_stall_pct <= recv_pct;
    endtask

    initial
    begin
        rst_n <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, no idling
        set_flow(0, 0);

        // default 1x1 grid: every cell is its own bottom-right corner
        send_cell(16'sh7fff);
        send_cell(16'sh8000);
        send_cell(16'sh0000);

        // zero rows acts as one row; a single row of most negative costs
        set_grid(CFG_BITS'(0), CFG_BITS'(3));
        repeat (3) send_cell(16'sh8000);

        // 2x2: the bottom-right cell takes the smaller of above and left
        set_grid(CFG_BITS'(2), CFG_BITS'(2));
        send_cell(16'sh7fff);
        send_cell(-16'sd1);
        send_cell(16'sd1);
        send_cell(16'sh8000);

        // 3x3 cut short by a register write, then a whole grid and one more cell from the top-left
        set_grid(CFG_BITS'(3), CFG_BITS'(3));
        repeat (5) send_cell(pick_cost());
        write_reg(REG_COL_COUNT, CFG_BITS'(3));
        repeat (10) send_cell(pick_cost());

        // tallest grid, row count above the maximum: one long column of minimum costs
        set_flow(11, 11);
        set_grid(CFG_BITS'(511), CFG_BITS'(1));
        repeat (256) send_cell(16'sh8000);

        // widest grid: one long row of random costs
        set_flow(0, 56);
        set_grid(CFG_BITS'(1), CFG_BITS'(256));
        repeat (256) send_cell(pick_cost());

        // receiver holds off while cells keep coming, so the block backs up
        set_flow(0, 0);
        set_grid(CFG_BITS'(4), CFG_BITS'(5));
        hold_toggle <= ~hold_toggle;
        repeat (HOLD_CELLS) send_cell(pick_cost());
        settle();

        // random phases: mostly whole grids, some cut short, flow pattern rotating
        random_sent = 0;
        phase       = 0;
        rows_eff    = 4;
        cols_eff    = 5;
        while (random_sent < RANDOM_CELLS)
        begin
            case (phase % 5)
                0:       set_flow(0, 0);
                1:       set_flow(56, 0);
                2:       set_flow(0, 56);
                3:       set_flow(11, 11);
                default: set_flow(0, 0);
            endcase

            // 0 both registers, 1 rows only, 2 columns only, 3 keep the grid going
            pick = $urandom_range(3);
            if (pick == 0 || pick == 1)
            begin
                size_val = pick_size(6);
                rows_eff = size_in_use(size_val, DEF_MAX_ROWS);
                write_reg(REG_ROW_COUNT, size_val);
            end
            if (pick == 0 || pick == 2)
            begin
                size_val = pick_size(8);
                cols_eff = size_in_use(size_val, DEF_MAX_COLS);
                write_reg(REG_COL_COUNT, size_val);
            end

            grid_cells = rows_eff * cols_eff;
            if (grid_cells > 60 || $urandom_range(4) == 0)
            begin
                burst = $urandom_range((grid_cells > 60) ? 60 : grid_cells, 1);
            end
            else
            begin
                burst = grid_cells * $urandom_range(3, 1);
            end

            repeat (burst)
            begin
                send_cell(pick_cost());
                random_sent++;
            end

            // now and then the sender waits for the block to drain
            if ($urandom_range(3) == 0)
            begin
                settle();
            end
            phase++;
        end

        // drain and give the verdict
        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
